@@ rtl/apft_pkg.sv @@
// Package for the aperture find-or-insert table.
// Holds field widths, the entry type, status codes, sequencer states and control struct.
// Depends on nothing.
package apft_pkg;

    localparam int WIDTH_W  = 31;
    localparam int SHAPE_W  = 3;
    localparam int CODE_W   = 11;
    localparam int STATUS_W = 2;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [SHAPE_W-1:0] shape;
    } t_entry;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_ADDED = 2'd1,
        ST_ZERO  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT
    } t_state;

    // Control from the sequencer to the entry store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctrl;

endpackage

@@ rtl/apft_store.sv @@
// Entry store of the aperture table: one write port and one registered read port.
// Depends on apft_pkg.
module apft_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  apft_pkg::t_store_ctrl i_ctrl,
    input  logic [AW-1:0]        i_wr_addr,
    input  apft_pkg::t_entry     i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output apft_pkg::t_entry     o_rd_data
);

    apft_pkg::t_entry r_mem [DEPTH];
    apft_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/apft_match.sv @@
// Shared compare unit: tests one stored entry against the pending request.
// Depends on apft_pkg.
module apft_match (
    input  apft_pkg::t_entry i_stored,
    input  apft_pkg::t_entry i_req,
    output logic             o_hit
);

    assign o_hit = (i_stored.width == i_req.width) && (i_stored.shape == i_req.shape);

endmodule

@@ rtl/aperture_find_or_insert_table.sv @@
// Top level of the aperture find-or-insert table.
// Holds the sequencer and instantiates apft_store and apft_match; depends on apft_pkg.
//
// A request (width, shape) is transferred at a rising edge where start is high and
// busy is low. Exactly one result follows, shown on o_status and o_code for one cycle
// with o_valid high; the receiver cannot hold it off, so it must take it then. A zero
// width answers in the cycle after the transfer with status "zero width" and code 0,
// and the block stays ready. Otherwise the stored entries are walked in insertion
// order through one registered memory read port and one compare unit, one entry per
// cycle. A hit ends the walk; a miss over all stored entries ends in "table full",
// or else the pair is appended through the memory write in the insert state. With an
// empty table the walk is skipped and the pair goes straight to the insert state.
// The block can take the next request in the cycle that shows the result. A new
// code is CODE_BASE plus the entry index.
// Reset empties the table at once; no clearing pass is needed.
module aperture_find_or_insert_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int CODE_BASE   = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [apft_pkg::WIDTH_W-1:0] i_req_width,
    input  logic [apft_pkg::SHAPE_W-1:0] i_req_shape,
    output logic                         o_valid,
    output logic [apft_pkg::STATUS_W-1:0] o_status,
    output logic [apft_pkg::CODE_W-1:0]  o_code
);

    // Index width for the entry store and count width that can hold TABLE_DEPTH.
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    apft_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [IW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_cmp_valid, n_cmp_valid;
    logic              r_cmp_last, n_cmp_last;
    apft_pkg::t_entry  r_req, n_req;
    logic              r_valid, n_valid;
    apft_pkg::t_status r_status, n_status;
    logic [apft_pkg::CODE_W-1:0] r_code, n_code;

    apft_pkg::t_store_ctrl store_ctrl;
    apft_pkg::t_entry      rd_data;
    logic                  hit;
    logic                  accept;
    logic                  table_full;

    apft_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctrl    (store_ctrl),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (r_req),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    apft_match u_match (
        .i_stored (rd_data),
        .i_req    (r_req),
        .o_hit    (hit)
    );

    assign busy       = (r_state != apft_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign table_full = (r_count == CW'(TABLE_DEPTH));

    // The state, fill count and valid flags take reset; the scan indices, the request and the result payload do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apft_pkg::S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_last <= n_cmp_last;
        r_req      <= n_req;
        r_status   <= n_status;
        r_code     <= n_code;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_last  = r_cmp_last;
        n_req       = r_req;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_code      = r_code;
        store_ctrl  = '0;

        case (r_state)
            apft_pkg::S_IDLE: begin
                if (accept) begin
                    n_req.width = i_req_width;
                    n_req.shape = i_req_shape;
                    n_rd_idx    = '0;
                    n_cmp_valid = 1'b0;
                    if (i_req_width == '0) begin
                        // Rejected at once; the table is left alone.
                        n_valid  = 1'b1;
                        n_status = apft_pkg::ST_ZERO;
                        n_code   = '0;
                    end else if (r_count == '0) begin
                        n_state = apft_pkg::S_INSERT;
                    end else begin
                        n_state = apft_pkg::S_SCAN;
                    end
                end
            end

            apft_pkg::S_SCAN: begin
                // The read of r_rd_idx is issued while the data of the previous
                // index, now registered, goes through the compare unit.
                store_ctrl.rd_en = 1'b1;
                if (r_cmp_valid && hit) begin
                    n_valid  = 1'b1;
                    n_status = apft_pkg::ST_FOUND;
                    n_code   = apft_pkg::CODE_W'(CODE_BASE)
                             + apft_pkg::CODE_W'(r_cmp_idx);
                    n_state  = apft_pkg::S_IDLE;
                end else if (r_cmp_valid && r_cmp_last) begin
                    if (table_full) begin
                        n_valid  = 1'b1;
                        n_status = apft_pkg::ST_FULL;
                        n_code   = '0;
                        n_state  = apft_pkg::S_IDLE;
                    end else begin
                        n_state = apft_pkg::S_INSERT;
                    end
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_rd_idx;
                    n_cmp_last  = ((CW'(r_rd_idx) + CW'(1)) == r_count);
                    if (!n_cmp_last) begin
                        n_rd_idx = r_rd_idx + IW'(1);
                    end
                end
            end

            apft_pkg::S_INSERT: begin
                store_ctrl.wr_en = 1'b1;
                n_count  = r_count + CW'(1);
                n_valid  = 1'b1;
                n_status = apft_pkg::ST_ADDED;
                n_code   = apft_pkg::CODE_W'(CODE_BASE) + apft_pkg::CODE_W'(r_count);
                n_state  = apft_pkg::S_IDLE;
            end

            default: begin
                n_state = apft_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_code   = r_code;

    // A result is only given while the sequencer is idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A zero width request answers in the next cycle with the rejection status.
    a_zero_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_width == '0) |=>
            (o_valid && o_status == apft_pkg::ST_ZERO && o_code == '0))
        else $error("zero width request not rejected at once");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A table-full answer carries no code, and the count did not move.
    a_full_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == apft_pkg::ST_FULL) |->
            (o_code == '0 && r_count == CW'(TABLE_DEPTH) && $stable(r_count)))
        else $error("table full result inconsistent");

endmodule

@@ tb/tb_aperture_find_or_insert_table.sv @@
// Self-checking testbench for the aperture find-or-insert table.
// Drives a directed table and then random requests, and predicts each answer locally.
// Depends on apft_pkg and aperture_find_or_insert_table.
`timescale 1ns / 1ps

module tb_aperture_find_or_insert_table;

    localparam int WIDTH_W     = apft_pkg::WIDTH_W;
    localparam int SHAPE_W     = apft_pkg::SHAPE_W;
    localparam int CODE_W      = apft_pkg::CODE_W;
    localparam int STATUS_W    = apft_pkg::STATUS_W;
    localparam int TABLE_DEPTH = 64;
    localparam int CODE_BASE   = 10;
    localparam int RANDOM_REQS = 1280;
    // Longest request is a full scan plus the append, so this covers any late result.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;

    typedef struct {
        apft_pkg::t_status  status;
        logic [CODE_W-1:0]  code;
    } t_answer;

    // One row of the directed table. Where fixed is set, the typed answer is the
    // expectation; otherwise the local predictor supplies it.
    typedef struct {
        logic [WIDTH_W-1:0] width;
        logic [SHAPE_W-1:0] shape;
        bit                 fixed;
        apft_pkg::t_status  status;
        logic [CODE_W-1:0]  code;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [WIDTH_W-1:0]    i_req_width;
    logic [SHAPE_W-1:0]    i_req_shape;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [CODE_W-1:0]     o_code;

    // Local copy of the aperture table; an accepted request that appends is added to it.
    logic [WIDTH_W-1:0]    stored_width [TABLE_DEPTH];
    logic [SHAPE_W-1:0]    stored_shape [TABLE_DEPTH];
    int                    stored_count;

    // Answers that have been predicted but not yet seen on the outputs, oldest first.
    t_answer               pending_answers [$];
    int                    mismatch_count;

    // Side channel from the driver: whether the request now on the ports carries
    // a typed answer. It is stable across the rising edge that accepts it.
    bit                    drv_fixed;
    apft_pkg::t_status     drv_fixed_status;
    logic [CODE_W-1:0]     drv_fixed_code;

    t_stim_row             dir_rows [$];

    aperture_find_or_insert_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_BASE   (CODE_BASE)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_width (i_req_width),
        .i_req_shape (i_req_shape),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_code      (o_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predicts the answer for one request and applies the append, if any, to the
    // local table. Stored pairs are distinct, so the first hit is the only hit.
    function automatic t_answer table_lookup(input logic [WIDTH_W-1:0] w,
                                             input logic [SHAPE_W-1:0] s);
        t_answer a;
        a.status = apft_pkg::ST_ZERO;
        a.code   = '0;
        if (w == '0) begin
            return a;
        end
        for (int k = 0; k < stored_count; k++) begin
            if (stored_width[k] == w && stored_shape[k] == s) begin
                a.status = apft_pkg::ST_FOUND;
                a.code   = CODE_W'(CODE_BASE + k);
                return a;
            end
        end
        if (stored_count >= TABLE_DEPTH) begin
            a.status = apft_pkg::ST_FULL;
            return a;
        end
        stored_width[stored_count] = w;
        stored_shape[stored_count] = s;
        a.status = apft_pkg::ST_ADDED;
        a.code   = CODE_W'(CODE_BASE + stored_count);
        stored_count++;
        return a;
    endfunction

    function automatic t_stim_row mk_row(input logic [WIDTH_W-1:0] w,
                                         input logic [SHAPE_W-1:0] s,
                                         input bit f,
                                         input apft_pkg::t_status st,
                                         input logic [CODE_W-1:0] c);
        t_stim_row r;
        r.width  = w;
        r.shape  = s;
        r.fixed  = f;
        r.status = st;
        r.code   = c;
        return r;
    endfunction

    // Widths are drawn from several families so that small values collide often
    // (giving hits) while large and single-bit values exercise every width bit.
    function automatic logic [WIDTH_W-1:0] pick_width();
        logic [WIDTH_W-1:0] w;
        case ($urandom_range(0, 4))
            0: begin
                w = WIDTH_W'($urandom());
            end
            1: begin
                w = WIDTH_W'($urandom_range(1, 8));
            end
            2: begin
                w = WIDTH_W'(1) << $urandom_range(0, WIDTH_W - 1);
            end
            3: begin
                w = {WIDTH_W{1'b1}} - WIDTH_W'($urandom_range(0, 3));
            end
            default: begin
                w = WIDTH_W'($urandom_range(1, 1000));
            end
        endcase
        return w;
    endfunction

    // Idle time before the next request. Mode 0 gives a stretch with no gaps.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Presents one request and holds it until it is transferred. Called and
    // returning at a falling edge, so each input is written once per edge.
    task automatic send_request(input logic [WIDTH_W-1:0] w,
                                input logic [SHAPE_W-1:0] s,
                                input bit f,
                                input apft_pkg::t_status st,
                                input logic [CODE_W-1:0] c);
        i_req_width      = w;
        i_req_shape      = s;
        drv_fixed        = f;
        drv_fixed_status = st;
        drv_fixed_code   = c;
        start            = 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding answer has come back.
    task automatic drain_answers();
        start = 1'b0;
        while (pending_answers.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Result checking and prediction, both at the rising edge. A zero-width answer
    // comes in the cycle after its transfer, so a check and a push never refer to
    // the same request at one edge.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result with none expected, status %0d code %0d",
                             $time, o_status, o_code);
                    mismatch_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_code !== want.code) begin
                        $display("%0t: code mismatch, expected %0d, actual %0d",
                                 $time, want.code, o_code);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                // The predictor always runs so that the local table stays in step,
                // even when the row supplies its own answer.
                got = table_lookup(i_req_width, i_req_shape);
                if (drv_fixed) begin
                    got.status = drv_fixed_status;
                    got.code   = drv_fixed_code;
                end
                pending_answers.push_back(got);
            end
        end
    end

    // Watchdog: a run that hangs or never drains its expectations fails here.
    initial begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int                 mode;
        int                 r;
        int                 idx;
        logic [WIDTH_W-1:0] w;
        logic [SHAPE_W-1:0] s;

        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_req_width      = '0;
        i_req_shape      = '0;
        drv_fixed        = 1'b0;
        drv_fixed_status = apft_pkg::ST_ZERO;
        drv_fixed_code   = '0;
        stored_count     = 0;
        mismatch_count   = 0;

        // Directed table. The first rows are readable straight from the rules:
        // an empty table appends from CODE_BASE upward, repeats hit, zero width
        // is rejected regardless of shape.
        dir_rows.push_back(mk_row(31'd0,         3'd0, 1, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd1,         3'd0, 1, apft_pkg::ST_ADDED, 11'd10));
        dir_rows.push_back(mk_row(31'h7FFF_FFFF, 3'd7, 1, apft_pkg::ST_ADDED, 11'd11));
        dir_rows.push_back(mk_row(31'd1,         3'd0, 1, apft_pkg::ST_FOUND, 11'd10));
        dir_rows.push_back(mk_row(31'h7FFF_FFFF, 3'd7, 1, apft_pkg::ST_FOUND, 11'd11));
        dir_rows.push_back(mk_row(31'd0,         3'd7, 1, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd1,         3'd7, 1, apft_pkg::ST_ADDED, 11'd12));
        dir_rows.push_back(mk_row(31'h7FFF_FFFF, 3'd0, 1, apft_pkg::ST_ADDED, 11'd13));
        // Remaining rows cover the other shapes, alternating width bits and near
        // misses on width or shape; their answers come from the predictor.
        dir_rows.push_back(mk_row(31'h5555_5555, 3'd2, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'h2AAA_AAAA, 3'd5, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd2,         3'd1, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd2,         3'd3, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd2,         3'd4, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd2,         3'd6, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd1,         3'd7, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'h5555_5555, 3'd5, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'h2AAA_AAAA, 3'd5, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'h7FFF_FFFE, 3'd7, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd2,         3'd6, 0, apft_pkg::ST_ZERO,  11'd0));
        dir_rows.push_back(mk_row(31'd0,         3'd3, 0, apft_pkg::ST_ZERO,  11'd0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) begin
            send_request(dir_rows[n].width, dir_rows[n].shape, dir_rows[n].fixed,
                         dir_rows[n].status, dir_rows[n].code);
            idle_for(pick_gap(1));
        end
        drain_answers();

        // Random part. Fresh pairs fill the table within the first couple of
        // hundred requests; after that they come back as table full, while
        // repeats of stored entries keep hitting at every depth of the scan.
        mode = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (n == RANDOM_REQS / 2) begin
                drain_answers();
            end
            r = $urandom_range(0, 99);
            s = SHAPE_W'($urandom_range(0, 7));
            if (r < 15) begin
                w = '0;
            end else if (r < 55 || stored_count == 0) begin
                w = pick_width();
            end else if (r < 85) begin
                idx = $urandom_range(0, stored_count - 1);
                w   = stored_width[idx];
                s   = stored_shape[idx];
            end else begin
                // Near miss: a stored pair with either the shape or the width off.
                idx = $urandom_range(0, stored_count - 1);
                w   = stored_width[idx];
                s   = stored_shape[idx];
                if ($urandom_range(0, 1) == 0) begin
                    s = s ^ SHAPE_W'($urandom_range(1, 7));
                end else begin
                    w = w + WIDTH_W'(1);
                end
            end
            send_request(w, s, 1'b0, apft_pkg::ST_ZERO, '0);
            idle_for(pick_gap(mode));
        end

        start = 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        // Any stray result from the block would appear within one full scan.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
